// ===== design/bisc_pkg.sv =====
// Shared types and constants of the bilinear image scaler.
// Used by bisc_front, bisc_back and bilinear_image_scaler_q8_8_core; no dependencies.
package bisc_pkg;

  // Item kinds carried from the front to the back
  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_INTERP = 1'b1
  } op_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_IN_WIDTH  = 2'd0,
    REG_IN_HEIGHT = 2'd1,
    REG_X_STEP    = 2'd2,
    REG_Y_STEP    = 2'd3
  } cfg_reg_t;

  localparam int CFG_DW = 24;

  localparam logic [8:0]  RST_IN_WIDTH  = 9'd256;
  localparam logic [8:0]  RST_IN_HEIGHT = 9'd256;
  localparam logic [23:0] RST_STEP      = 24'd65536;

  // Pixel and result range
  localparam logic [7:0] PIX_MAX = 8'd255;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [8:0]  in_width;
    logic [8:0]  in_height;
    logic [23:0] x_step;
    logic [23:0] y_step;
  } cfg_t;

  // One queued item: col/row hold the source pixel for a load, the output
  // coordinate for an interpolation
  typedef struct packed {
    op_t         op;
    logic [11:0] col;
    logic [11:0] row;
    logic [7:0]  value;
  } qent_t;

  typedef struct packed {
    logic  valid;
    qent_t ent;
  } qhead_t;

endpackage

// ===== design/bisc_front.sv =====
// Front end of the scaler: accepts input transactions, drops loads outside
// the store and queues the rest for the back end. Depends on bisc_pkg.
module bisc_front #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic [7:0]         in_src_col,
  input  logic [7:0]         in_src_row,
  input  logic [7:0]         in_src_value,
  input  logic [11:0]        in_out_col,
  input  logic [11:0]        in_out_row,
  output bisc_pkg::qhead_t   head,
  input  logic               take
);

  localparam logic [12:0] MaxW = 13'(MAX_WIDTH);
  localparam logic [12:0] MaxH = 13'(MAX_HEIGHT);

  bisc_pkg::qent_t            q_mem_r [bisc_pkg::QDEPTH];
  logic [bisc_pkg::QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [bisc_pkg::QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [bisc_pkg::QCW-1:0]   count_r, count_nxt;

  bisc_pkg::op_t   op;
  bisc_pkg::qent_t ent;
  logic            in_range;
  logic            full;
  logic            push;
  logic            pop;

  // Classify the incoming transaction
  always_comb begin
    op       = bisc_pkg::op_t'(in_req_type);
    in_range = ({5'b0, in_src_col} < MaxW) && ({5'b0, in_src_row} < MaxH);
    ent.op   = op;
    if (op == bisc_pkg::OP_LOAD) begin
      ent.col   = {4'b0, in_src_col};
      ent.row   = {4'b0, in_src_row};
      ent.value = in_src_value;
    end else begin
      ent.col   = in_out_col;
      ent.row   = in_out_row;
      ent.value = in_src_value;
    end
  end

  assign full     = (count_r == bisc_pkg::QCW'(bisc_pkg::QDEPTH));
  assign in_stall = full;
  assign push     = in_valid && !full && ((op == bisc_pkg::OP_INTERP) || in_range);
  assign pop      = take && (count_r != '0);

  // Queue pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the queued entry
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= ent;
    end
  end

  assign head.valid = (count_r != '0);
  assign head.ent   = q_mem_r[rd_ptr_r];

endmodule

// ===== design/bisc_back.sv =====
// Back end of the scaler: coordinate multiply, banked image store, weights,
// weighted sum and output register. Depends on bisc_pkg.
module bisc_back #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bisc_pkg::cfg_t     cfg,
  input  bisc_pkg::qhead_t   head,
  output logic               take,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_value
);

  // Column/row index widths; at least two bits so every bank has an address
  localparam int XW    = ($clog2(MAX_WIDTH) > 1) ? $clog2(MAX_WIDTH) : 2;
  localparam int YW    = ($clog2(MAX_HEIGHT) > 1) ? $clog2(MAX_HEIGHT) : 2;
  localparam int BAW   = (XW - 1) + (YW - 1);
  localparam int BD    = 1 << BAW;
  localparam int NBANK = 4;

  localparam logic [12:0] MaxW = 13'(MAX_WIDTH);
  localparam logic [12:0] MaxH = 13'(MAX_HEIGHT);

  logic adv;

  // Stage A: multiplied coordinates
  logic              a_valid_r, a_valid_nxt;
  bisc_pkg::op_t     a_op_r;
  logic [11:0]       a_col_r, a_row_r;
  logic [7:0]        a_value_r;
  logic [35:0]       a_posx_r, a_posy_r;

  // Stage B: store read data and fractions
  logic              b_valid_r, b_valid_nxt;
  logic [7:0]        rd_r [NBANK];
  logic [7:0]        b_a_r, b_b_r;
  logic              b_x0p_r, b_y0p_r, b_dupx_r, b_dupy_r;

  // Stage C: selected pixels and weights
  logic              c_valid_r;
  logic [7:0]        c_p00_r, c_p10_r, c_p01_r, c_p11_r;
  logic [8:0]        c_w00_r, c_w10_r, c_w01_r, c_w11_r;

  // Stage D: weighted pixels
  logic              d_valid_r;
  logic [16:0]       d_m00_r, d_m10_r, d_m01_r, d_m11_r;

  logic              out_valid_r;
  logic [7:0]        out_value_r, out_value_nxt;

  // Whole pipeline moves together unless a finished result is held
  assign adv  = !out_valid_r || !out_stall;
  assign take = adv;

  // Effective last pixel index per axis
  logic [12:0]   wx, hy, lastx13, lasty13;
  logic [XW-1:0] lastx;
  logic [YW-1:0] lasty;

  always_comb begin
    wx = {4'b0, cfg.in_width};
    hy = {4'b0, cfg.in_height};
    if (wx == '0) begin
      lastx13 = '0;
    end else if (wx > MaxW) begin
      lastx13 = MaxW - 13'd1;
    end else begin
      lastx13 = wx - 13'd1;
    end
    if (hy == '0) begin
      lasty13 = '0;
    end else if (hy > MaxH) begin
      lasty13 = MaxH - 13'd1;
    end else begin
      lasty13 = hy - 13'd1;
    end
    lastx = lastx13[XW-1:0];
    lasty = lasty13[YW-1:0];
  end

  // Floor and clamp the source coordinate
  logic [19:0]   ipx, ipy;
  logic          clampx, clampy, dupx, dupy;
  logic [XW-1:0] x0;
  logic [YW-1:0] y0;
  logic [7:0]    fa, fb;
  logic [XW-2:0] x0h, x0h_inc;
  logic [YW-2:0] y0h, y0h_inc;

  always_comb begin
    ipx    = a_posx_r[35:16];
    ipy    = a_posy_r[35:16];
    clampx = ipx > 20'(lastx);
    clampy = ipy > 20'(lasty);
    x0     = clampx ? lastx : ipx[XW-1:0];
    y0     = clampy ? lasty : ipy[YW-1:0];
    dupx   = clampx || (x0 == lastx);
    dupy   = clampy || (y0 == lasty);
    fa     = clampx ? 8'd0 : a_posx_r[15:8];
    fb     = clampy ? 8'd0 : a_posy_r[15:8];
    // Even banks hold the neighbour one past an odd coordinate
    x0h     = x0[XW-1:1];
    y0h     = y0[YW-1:1];
    x0h_inc = x0h + (XW-1)'(x0[0]);
    y0h_inc = y0h + (YW-1)'(y0[0]);
  end

  // Parity banks: one read or one write each per cycle
  logic [XW-1:0] ld_col;
  logic [YW-1:0] ld_row;
  assign ld_col = a_col_r[XW-1:0];
  assign ld_row = a_row_r[YW-1:0];

  for (genvar k = 0; k < NBANK; k++) begin : g_bank
    localparam logic XP = 1'(k % 2);
    localparam logic YP = 1'(k / 2);
    logic [7:0]     mem [BD];
    logic [BAW-1:0] raddr, waddr;
    logic           we, re;

    assign raddr = {(YP ? y0h : y0h_inc), (XP ? x0h : x0h_inc)};
    assign waddr = {ld_row[YW-1:1], ld_col[XW-1:1]};
    assign we    = adv && a_valid_r && (a_op_r == bisc_pkg::OP_LOAD)
                   && (ld_col[0] == XP) && (ld_row[0] == YP);
    assign re    = adv && a_valid_r && (a_op_r == bisc_pkg::OP_INTERP);

    always_ff @(posedge clk) begin
      if (we) begin
        mem[waddr] <= a_value_r;
      end
      if (re) begin
        rd_r[k] <= mem[raddr];
      end
    end
  end

  // Route bank data to the four neighbours and form the weights
  logic       x1p, y1p;
  logic [8:0] ia, ib;
  logic [17:0] pw00, pw10, pw01, pw11;

  always_comb begin
    x1p  = b_dupx_r ? b_x0p_r : !b_x0p_r;
    y1p  = b_dupy_r ? b_y0p_r : !b_y0p_r;
    ia   = 9'd256 - {1'b0, b_a_r};
    ib   = 9'd256 - {1'b0, b_b_r};
    pw00 = ia * ib;
    pw10 = {1'b0, b_a_r} * ib;
    pw01 = ia * {1'b0, b_b_r};
    pw11 = {1'b0, b_a_r} * {1'b0, b_b_r};
  end

  // Sum the weighted pixels and clamp
  logic [18:0] sum;
  logic [10:0] sum_sh;

  always_comb begin
    sum    = 19'(d_m00_r) + 19'(d_m10_r) + 19'(d_m01_r) + 19'(d_m11_r);
    sum_sh = sum[18:8];
    out_value_nxt = (sum_sh > 11'(bisc_pkg::PIX_MAX)) ? bisc_pkg::PIX_MAX : sum_sh[7:0];
  end

  assign a_valid_nxt = head.valid;
  assign b_valid_nxt = a_valid_r && (a_op_r == bisc_pkg::OP_INTERP);

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      d_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r   <= a_valid_nxt;
      b_valid_r   <= b_valid_nxt;
      c_valid_r   <= b_valid_r;
      d_valid_r   <= c_valid_r;
      out_valid_r <= d_valid_r;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      a_op_r    <= head.ent.op;
      a_col_r   <= head.ent.col;
      a_row_r   <= head.ent.row;
      a_value_r <= head.ent.value;
      a_posx_r  <= 36'(head.ent.col) * 36'(cfg.x_step);
      a_posy_r  <= 36'(head.ent.row) * 36'(cfg.y_step);

      b_a_r    <= fa;
      b_b_r    <= fb;
      b_x0p_r  <= x0[0];
      b_y0p_r  <= y0[0];
      b_dupx_r <= dupx;
      b_dupy_r <= dupy;

      c_p00_r <= rd_r[{b_y0p_r, b_x0p_r}];
      c_p10_r <= rd_r[{b_y0p_r, x1p}];
      c_p01_r <= rd_r[{y1p, b_x0p_r}];
      c_p11_r <= rd_r[{y1p, x1p}];
      c_w00_r <= pw00[16:8];
      c_w10_r <= pw10[16:8];
      c_w01_r <= pw01[16:8];
      c_w11_r <= pw11[16:8];

      d_m00_r <= c_p00_r * c_w00_r;
      d_m10_r <= c_p10_r * c_w10_r;
      d_m01_r <= c_p01_r * c_w01_r;
      d_m11_r <= c_p11_r * c_w11_r;

      out_value_r <= out_value_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

endmodule

// ===== design/bilinear_image_scaler_q8_8_core.sv =====
// Top level of the grayscale bilinear scaler: configuration registers,
// front end queue and back end pipeline. Depends on bisc_pkg, bisc_front, bisc_back.
//
// Usage:
//   Input channel (in_valid / in_stall): in_req_type 0 loads in_src_value at
//   (in_src_col, in_src_row) into the image store and gives no result; a load
//   outside MAX_WIDTH x MAX_HEIGHT is dropped. in_req_type 1 interpolates the
//   output pixel (in_out_col, in_out_row) and gives one result.
//   Result channel (out_valid / out_stall): out_value, the blended gray level.
//   Configuration (cfg_wr_en, cfg_index, cfg_data): in_width, in_height,
//   x_step, y_step (Q8.16); write only while no transaction is in flight.
//   Throughput: one transaction per cycle while out_stall does not freeze the
//   back pipeline, set by the four parity banks of the store (even/odd column
//   x even/odd row), which serve all four neighbours in a single read.
//   Path: an accepted transaction passes the queue, multiply, store read,
//   weights, products and sum registers before out_valid.
//   Reset: clears the queue, pipeline valids and config to 256 x 256 with
//   unit steps; the store content stays undefined until loaded.
//   Stall: out_stall while out_valid is high freezes the back pipeline; the
//   four-entry queue then fills and in_stall rises.
module bilinear_image_scaler_q8_8_core #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_req_type,
  input  logic [7:0]                    in_src_col,
  input  logic [7:0]                    in_src_row,
  input  logic [7:0]                    in_src_value,
  input  logic [11:0]                   in_out_col,
  input  logic [11:0]                   in_out_row,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_value,
  input  logic                          cfg_wr_en,
  input  logic [1:0]                    cfg_index,
  input  logic [bisc_pkg::CFG_DW-1:0]   cfg_data
);

  bisc_pkg::cfg_t   cfg_r, cfg_nxt;
  bisc_pkg::qhead_t head;
  logic             take;

  // Register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (bisc_pkg::cfg_reg_t'(cfg_index))
        bisc_pkg::REG_IN_WIDTH:  cfg_nxt.in_width  = cfg_data[8:0];
        bisc_pkg::REG_IN_HEIGHT: cfg_nxt.in_height = cfg_data[8:0];
        bisc_pkg::REG_X_STEP:    cfg_nxt.x_step    = cfg_data[23:0];
        bisc_pkg::REG_Y_STEP:    cfg_nxt.y_step    = cfg_data[23:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.in_width  <= bisc_pkg::RST_IN_WIDTH;
      cfg_r.in_height <= bisc_pkg::RST_IN_HEIGHT;
      cfg_r.x_step    <= bisc_pkg::RST_STEP;
      cfg_r.y_step    <= bisc_pkg::RST_STEP;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bisc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_src_col   (in_src_col),
    .in_src_row   (in_src_row),
    .in_src_value (in_src_value),
    .in_out_col   (in_out_col),
    .in_out_row   (in_out_row),
    .head         (head),
    .take         (take)
  );

  bisc_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head      (head),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_value (out_value)
  );

endmodule
